// ===== rtl/core/gdnc_pkg.sv =====
`default_nettype none

package gdnc_pkg;

    typedef struct packed {
        logic        func;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [22:0] day_number_in;
    } t_req;

    typedef struct packed {
        logic [22:0] day_number_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        out_of_range;
    } t_rsp;

    // register stages from request to result, output register included
    localparam int unsigned STG_N = 7;

    localparam logic        FUNC_TO_JDN  = 1'b0;

    localparam logic [22:0] JDN_MIN      = 23'd1721060;
    localparam logic [22:0] JDN_MAX      = 23'd5373484;
    localparam logic [12:0] YEAR_BIAS    = 13'd4800;
    localparam logic [14:0] JDN_BIAS     = 15'd32045;
    localparam logic [14:0] A_BIAS       = 15'd32044;
    localparam logic [8:0]  DAYS_YEAR    = 9'd365;
    localparam logic [17:0] DAYS_400Y    = 18'd146097;
    localparam logic [10:0] DAYS_4Y      = 11'd1461;
    localparam logic [6:0]  YEARS_CENT   = 7'd100;

    // reciprocal multipliers, exact over the operand ranges in use
    localparam int unsigned Y100_SH = 22;
    localparam int unsigned B_SH    = 43;
    localparam int unsigned D_SH    = 29;
    localparam int unsigned M_SH    = 19;

    localparam logic [15:0] K_Y100 = 16'(((64'd1 << Y100_SH) + 64'd99) / 64'd100);
    localparam logic [25:0] K_B    = 26'(((64'd1 << B_SH) + 64'd146096) / 64'd146097);
    localparam logic [18:0] K_D    = 19'(((64'd1 << D_SH) + 64'd1460) / 64'd1461);
    localparam logic [11:0] K_M    = 12'(((64'd1 << M_SH) + 64'd152) / 64'd153);

    // days before the start of march-based month m, (153m + 2) / 5
    function automatic logic [8:0] f_mtab(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gregorian_day_number_convert_unit.sv =====
// Gregorian date <-> Julian day number converter.
// Request channel: i_valid / o_stall with payload i_req. func = 0 turns
// year_in, month_in and day_in into day_number_out; func = 1 turns
// day_number_in into year_out, month_out and day_out. A day number outside
// 1721060..5373484 returns out_of_range with a zero date.
// Result channel: o_valid / i_stall with payload o_rsp, one result per
// request, in request order.
// Seven register stages carry a request to o_valid, the first loaded at
// the accepting edge, the longest chain being the reciprocal multiplies of
// the day number path. One request is taken every cycle while o_stall is
// low. Each stage has its own valid bit and only holds while it is full
// and the stage after it holds, so a stall on i_stall first fills the
// empty stages and raises o_stall only once all seven are occupied.
// A stalled result stays unchanged on o_rsp.
// Synchronous reset (i_rst_n low) empties the pipeline; no state survives
// between requests.
`default_nettype none

module gregorian_day_number_convert_unit import gdnc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    logic [STG_N:1]   adv;
    logic [STG_N:1]   r_vld;
    logic [STG_N-1:1] r_func;
    logic [STG_N-1:1] r_oor;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             oor_in;
    logic [22:0]      jdn_res;
    logic [13:0]      year_res;
    logic [3:0]       month_res;
    logic [4:0]       day_res;

    always_comb begin
        adv[STG_N] = !r_vld[STG_N] || !i_stall;
        for (int k = STG_N - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[1];
    assign o_valid = r_vld[STG_N];
    assign o_rsp   = r_rsp;
    assign oor_in  = (i_req.day_number_in < JDN_MIN) || (i_req.day_number_in > JDN_MAX);

    gdnc_to_jdn u_to_jdn (
        .i_clk   (i_clk),
        .i_adv   (adv[STG_N-1:1]),
        .i_year  (i_req.year_in),
        .i_month (i_req.month_in),
        .i_day   (i_req.day_in),
        .o_jdn   (jdn_res)
    );

    gdnc_to_date u_to_date (
        .i_clk   (i_clk),
        .i_adv   (adv[STG_N-1:1]),
        .i_jdn   (i_req.day_number_in),
        .o_year  (year_res),
        .o_month (month_res),
        .o_day   (day_res)
    );

    always_comb begin
        n_rsp = '0;
        if (r_func[STG_N-1] == FUNC_TO_JDN) begin
            n_rsp.day_number_out = jdn_res;
        end else if (r_oor[STG_N-1]) begin
            n_rsp.out_of_range = 1'b1;
        end else begin
            n_rsp.year_out  = year_res;
            n_rsp.month_out = month_res;
            n_rsp.day_out   = day_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= STG_N; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_func[1] <= i_req.func;
            r_oor[1]  <= oor_in;
        end
        for (int k = 2; k <= STG_N - 1; k++) begin
            if (adv[k]) begin
                r_func[k] <= r_func[k-1];
                r_oor[k]  <= r_oor[k-1];
            end
        end
        if (adv[STG_N]) begin
            r_rsp <= n_rsp;
        end
    end

    a_oor_zero_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.out_of_range) |->
        (o_rsp.year_out == '0 && o_rsp.month_out == '0 && o_rsp.day_out == '0
         && o_rsp.day_number_out == '0))
        else $error("range error result carries a date");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld && i_stall))
        else $error("request stalled with room in the pipeline");

    a_no_lost_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && adv[2]) |=> r_vld[2])
        else $error("request dropped between stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[STG_N-1] && adv[STG_N]) |=> !o_valid)
        else $error("result raised from an empty stage");

endmodule

`default_nettype wire

// ===== rtl/core/gdnc_to_jdn.sv =====
`default_nettype none

module gdnc_to_jdn import gdnc_pkg::*; (
    input  logic              i_clk,
    input  logic [STG_N-2:0]  i_adv,
    input  logic [13:0]       i_year,
    input  logic [3:0]        i_month,
    input  logic [4:0]        i_day,
    output logic [22:0]       o_jdn
);

    logic        lo_feb;
    logic [14:0] n_y;
    logic [3:0]  n_m;
    logic [8:0]  q100;
    logic [24:0] sum;

    logic [14:0] r1_y;
    logic [8:0]  r1_t;
    logic [4:0]  r1_day;

    logic [23:0] r2_y365;
    logic [30:0] r2_yp;
    logic [14:0] r2_y;
    logic [8:0]  r2_t;
    logic [4:0]  r2_day;

    logic [22:0] r3_jdn;
    logic [22:0] r4_jdn;
    logic [22:0] r5_jdn;
    logic [22:0] r6_jdn;

    always_comb begin
        lo_feb = (i_month <= 4'd2);
        n_y    = 15'(i_year) + 15'(YEAR_BIAS) - 15'(lo_feb);
        n_m    = lo_feb ? (i_month + 4'd9) : (i_month - 4'd3);
        q100   = r2_yp[30:Y100_SH];
        sum    = 25'(r2_y365) + 25'(r2_y[14:2]) + 25'(q100[8:2]) + 25'(r2_t)
               + 25'(r2_day) - 25'(q100) - 25'(JDN_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r1_y   <= n_y;
            r1_t   <= f_mtab(n_m);
            r1_day <= i_day;
        end
        if (i_adv[1]) begin
            r2_y365 <= r1_y * DAYS_YEAR;
            r2_yp   <= r1_y * K_Y100;
            r2_y    <= r1_y;
            r2_t    <= r1_t;
            r2_day  <= r1_day;
        end
        if (i_adv[2]) begin
            r3_jdn <= sum[22:0];
        end
        if (i_adv[3]) begin
            r4_jdn <= r3_jdn;
        end
        if (i_adv[4]) begin
            r5_jdn <= r4_jdn;
        end
        if (i_adv[5]) begin
            r6_jdn <= r5_jdn;
        end
    end

    assign o_jdn = r6_jdn;

endmodule

`default_nettype wire

// ===== rtl/core/gdnc_to_date.sv =====
`default_nettype none

module gdnc_to_date import gdnc_pkg::*; (
    input  logic              i_clk,
    input  logic [STG_N-2:0]  i_adv,
    input  logic [22:0]       i_jdn,
    output logic [13:0]       o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day
);

    logic [23:0] n_a;
    logic [8:0]  b;
    logic [26:0] bb;
    logic [24:0] c_full;
    logic [7:0]  d;
    logic [18:0] dd;
    logic [15:0] e_full;
    logic [11:0] ex;
    logic [3:0]  m;
    logic        m10;
    logic [16:0] yr;

    logic [23:0] r1_a;

    logic [51:0] r2_bp;
    logic [23:0] r2_a;

    logic [8:0]  r3_b;
    logic [15:0] r3_c;

    logic [36:0] r4_dp;
    logic [8:0]  r4_b;
    logic [15:0] r4_c;

    logic [8:0]  r5_b;
    logic [7:0]  r5_d;
    logic [8:0]  r5_e;

    logic [23:0] r6_mp;
    logic [8:0]  r6_b;
    logic [7:0]  r6_d;
    logic [8:0]  r6_e;

    always_comb begin
        n_a    = 24'(i_jdn) + 24'(A_BIAS);
        b      = r2_bp[51:B_SH];
        bb     = b * DAYS_400Y;
        c_full = 25'(r2_a) - 25'(bb[26:2]);
        d      = r4_dp[36:D_SH];
        dd     = d * DAYS_4Y;
        e_full = r4_c - 16'(dd[18:2]);
        ex     = 12'(r5_e) * 12'd5 + 12'd2;
        m      = r6_mp[M_SH+3:M_SH];
        m10    = (m >= 4'd10);
        yr     = 17'(r6_b) * 17'(YEARS_CENT) + 17'(r6_d) + 17'(m10) - 17'(YEAR_BIAS);
        o_year  = yr[13:0];
        o_month = m10 ? (m - 4'd9) : (m + 4'd3);
        o_day   = 5'(r6_e + 9'd1 - f_mtab(m));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r1_a <= n_a;
        end
        if (i_adv[1]) begin
            r2_bp <= {r1_a, 2'b11} * K_B;
            r2_a  <= r1_a;
        end
        if (i_adv[2]) begin
            r3_b <= b;
            r3_c <= c_full[15:0];
        end
        if (i_adv[3]) begin
            r4_dp <= {r3_c, 2'b11} * K_D;
            r4_b  <= r3_b;
            r4_c  <= r3_c;
        end
        if (i_adv[4]) begin
            r5_b <= r4_b;
            r5_d <= d;
            r5_e <= e_full[8:0];
        end
        if (i_adv[5]) begin
            r6_mp <= ex * K_M;
            r6_b  <= r5_b;
            r6_d  <= r5_d;
            r6_e  <= r5_e;
        end
    end

endmodule

`default_nettype wire

// ===== tb/gregorian_day_number_convert_unit_test.sv =====
`timescale 1ns / 1ps

module gregorian_day_number_convert_unit_test;
    import gdnc_pkg::*;

    localparam logic FUNC_TO_DATE  = ~FUNC_TO_JDN;
    localparam int   RANDOM_ITEMS  = 750;
    localparam int   CALM_ITEMS    = 120;
    localparam int   CYCLE_LIMIT   = 200000;

    class conversion_ledger;
        t_rsp expected_dates[$];

        function t_rsp convert_date(t_req r);
            int unsigned a, y, m, b, c, d, e, jdn;
            t_rsp p;
            p = '0;
            if (r.func == FUNC_TO_JDN) begin
                a = (r.month_in <= 4'd2) ? 1 : 0;
                y = int'(r.year_in) + 4800 - a;
                m = int'(r.month_in) + 12 * a - 3;
                p.day_number_out = 23'(int'(r.day_in) + (m * 153 + 2) / 5 + y * 365
                                       + y / 4 - y / 100 + y / 400 - 32045);
            end else begin
                jdn = int'(r.day_number_in);
                if (jdn < int'(JDN_MIN) || jdn > int'(JDN_MAX)) begin
                    p.out_of_range = 1'b1;
                end else begin
                    a = jdn + 32044;
                    b = (a * 4 + 3) / 146097;
                    c = a - (b * 146097) / 4;
                    d = (c * 4 + 3) / 1461;
                    e = c - (d * 1461) / 4;
                    m = (e * 5 + 2) / 153;
                    p.year_out  = 14'(b * 100 + d + m / 10 - 4800);
                    p.month_out = 4'(m + 3 - (m / 10) * 12);
                    p.day_out   = 5'(e + 1 - (m * 153 + 2) / 5);
                end
            end
            return p;
        endfunction

        function void note_request(t_req r);
            expected_dates.push_back(convert_date(r));
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        function bit check_result(t_rsp got, output string what);
            t_rsp want;
            what = "";
            if (expected_dates.size() == 0) begin
                what = $sformatf("result %h with no request waiting", got);
                return 1'b1;
            end
            want = expected_dates.pop_front();
            if (got.day_number_out != want.day_number_out)
                what = {what, $sformatf(" day_number %0d want %0d",
                                        got.day_number_out, want.day_number_out)};
            if (got.year_out != want.year_out)
                what = {what, $sformatf(" year %0d want %0d", got.year_out, want.year_out)};
            if (got.month_out != want.month_out)
                what = {what, $sformatf(" month %0d want %0d", got.month_out, want.month_out)};
            if (got.day_out != want.day_out)
                what = {what, $sformatf(" day %0d want %0d", got.day_out, want.day_out)};
            if (got.out_of_range != want.out_of_range)
                what = {what, $sformatf(" out_of_range %0d want %0d",
                                        got.out_of_range, want.out_of_range)};
            return what != "";
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    conversion_ledger ledger;
    int   mismatches;
    int   cycles;
    logic calm;
    string what;

    gregorian_day_number_convert_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d:%s", cycles, msg);
        mismatches++;
    endtask

    function automatic t_req noise_request();
        t_req r;
        r.func          = 1'($urandom);
        r.year_in       = 14'($urandom);
        r.month_in      = 4'($urandom);
        r.day_in        = 5'($urandom);
        r.day_number_in = 23'($urandom);
        return r;
    endfunction

    function automatic t_req date_request(input int year, input int month, input int day);
        t_req r;
        r          = noise_request();
        r.func     = FUNC_TO_JDN;
        r.year_in  = 14'(year);
        r.month_in = 4'(month);
        r.day_in   = 5'(day);
        return r;
    endfunction

    function automatic t_req jdn_request(input int jdn);
        t_req r;
        r               = noise_request();
        r.func          = FUNC_TO_DATE;
        r.day_number_in = 23'(jdn);
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        r    = noise_request();
        pick = $urandom_range(0, 9);
        if (r.func == FUNC_TO_JDN) begin
            if (pick < 8)
                r = date_request($urandom_range(0, 9999), $urandom_range(1, 12),
                                 $urandom_range(1, 31));
        end else begin
            if (pick < 6)
                r.day_number_in = 23'($urandom_range(JDN_MIN, JDN_MAX));
            else if (pick < 7)
                r.day_number_in = JDN_MIN - 23'd3 + 23'($urandom_range(0, 6));
            else if (pick < 8)
                r.day_number_in = JDN_MAX - 23'd3 + 23'($urandom_range(0, 6));
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        ledger.note_request(r);
    endtask

    task automatic pause_sender();
        i_valid <= 1'b0;
        i_req   <= noise_request();
        repeat ($urandom_range(1, 13)) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (ledger.check_result(o_rsp, what))
                report_mismatch(what);
        end
    end

    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_req directed[$];
        ledger     = new();
        mismatches = 0;
        cycles     = 0;
        calm       = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_req      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(date_request(0, 1, 1));
        directed.push_back(date_request(9999, 12, 31));
        directed.push_back(date_request(2000, 2, 29));
        directed.push_back(date_request(1900, 2, 29));
        directed.push_back(date_request(2023, 2, 31));
        directed.push_back(date_request(2024, 1, 0));
        directed.push_back(date_request(2024, 0, 15));
        directed.push_back(date_request(2024, 13, 1));
        directed.push_back(date_request(2024, 15, 31));
        directed.push_back(date_request(16383, 15, 31));
        directed.push_back(date_request(0, 0, 0));
        directed.push_back(date_request(1582, 10, 15));
        directed.push_back(jdn_request(JDN_MIN));
        directed.push_back(jdn_request(JDN_MAX));
        directed.push_back(jdn_request(JDN_MIN - 1));
        directed.push_back(jdn_request(JDN_MAX + 1));
        directed.push_back(jdn_request(0));
        directed.push_back(jdn_request(23'h7fffff));
        directed.push_back(jdn_request(2451545));
        directed.push_back(jdn_request(2460311));
        foreach (directed[k]) begin
            send_request(directed[k]);
            if ($urandom_range(0, 3) == 0)
                pause_sender();
        end

        // drain before random traffic
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0) @(posedge i_clk);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (!calm && (k / 64) % 3 != 2 && $urandom_range(0, 4) == 0)
                pause_sender();
            send_request(random_request());
        end
        i_valid <= 1'b0;

        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (STG_N + 5) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gdnc_pkg.sv
rtl/core/gdnc_to_jdn.sv
rtl/core/gdnc_to_date.sv
rtl/core/gregorian_day_number_convert_unit.sv
tb/gregorian_day_number_convert_unit_test.sv
